@@ src/ncva_pkg.sv @@
`default_nettype none

package ncva_pkg;

  // Fixed-point format of the axes and width of the input integers.
  localparam int FRAC_BITS  = 14;
  localparam int IN_WIDTH   = 16;
  localparam int AXIS_WIDTH = FRAC_BITS + 2;
  localparam int Q_WIDTH    = FRAC_BITS + 1;
  localparam int SUM_WIDTH  = 2 * IN_WIDTH;
  localparam int WIDE_WIDTH = 2 * IN_WIDTH + 2 * FRAC_BITS + 3;
  localparam int PROD_WIDTH = 2 * AXIS_WIDTH;

  // Delay from an accepted start to the done strobe.
  localparam int LATENCY    = FRAC_BITS + 6;

  // Configuration register map.
  localparam int ADDR_WIDTH = 4;
  localparam logic [1:0] REG_Z_AXIS_X = 2'd0;
  localparam logic [1:0] REG_Z_AXIS_Y = 2'd1;
  localparam logic [1:0] REG_Z_AXIS_Z = 2'd2;

  localparam logic OP_VEC_IS_X = 1'b0;
  localparam logic OP_VEC_IS_Y = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic signed [IN_WIDTH-1:0] vec_x;
    logic signed [IN_WIDTH-1:0] vec_y;
    logic signed [IN_WIDTH-1:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [AXIS_WIDTH-1:0] x_axis_x;
    logic signed [AXIS_WIDTH-1:0] x_axis_y;
    logic signed [AXIS_WIDTH-1:0] x_axis_z;
    logic signed [AXIS_WIDTH-1:0] y_axis_x;
    logic signed [AXIS_WIDTH-1:0] y_axis_y;
    logic signed [AXIS_WIDTH-1:0] y_axis_z;
    logic                         zero_length;
  } out_t;

  // One component as it travels along the chain of root cells.
  typedef struct packed {
    logic [WIDE_WIDTH-1:0] r;   // mag^2 scaled to the comparison
    logic [WIDE_WIDTH-1:0] qs;  // q * s
    logic [WIDE_WIDTH-1:0] p;   // q^2 * s
    logic [Q_WIDTH-1:0]    q;
    logic                  neg;
  } lane_t;

  typedef struct packed {
    logic                 opcode;
    logic                 zero;
    logic [SUM_WIDTH-1:0] s;
    lane_t [2:0]          lane;
  } cell_t;

endpackage

`default_nettype wire

@@ src/ncva_cell.sv @@
`default_nettype none

module ncva_cell import ncva_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire cell_t in_data,
  output logic       out_valid,
  output cell_t      out_data
);

  logic [WIDE_WIDTH-1:0] c1   [3];
  logic [WIDE_WIDTH-1:0] c2   [3];
  logic [WIDE_WIDTH-1:0] lhs  [3];
  logic [WIDE_WIDTH-1:0] s_w;
  cell_t                 data_next;

  // Try bit BIT of each quotient: with c = q + 2^BIT the test is
  // (2c-1)^2 * s <= r, built from the running q*s and q^2*s by shifts and adds.
  always_comb begin
    s_w       = WIDE_WIDTH'(in_data.s);
    data_next = in_data;
    for (int i = 0; i < 3; i++) begin
      c1[i]  = in_data.lane[i].qs + (s_w << BIT);
      c2[i]  = in_data.lane[i].p + (in_data.lane[i].qs << (BIT + 1)) + (s_w << (2 * BIT));
      lhs[i] = (c2[i] << 2) - (c1[i] << 2) + s_w;
      if (!in_data.lane[i].q[Q_WIDTH-1] && (lhs[i] <= in_data.lane[i].r)) begin
        data_next.lane[i].q  = in_data.lane[i].q | (Q_WIDTH'(1) << BIT);
        data_next.lane[i].qs = c1[i];
        data_next.lane[i].p  = c2[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire

@@ src/ncva_cross.sv @@
`default_nettype none

module ncva_cross import ncva_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire cell_t                        in_data,
  input  wire logic signed [AXIS_WIDTH-1:0] z_x,
  input  wire logic signed [AXIS_WIDTH-1:0] z_y,
  input  wire logic signed [AXIS_WIDTH-1:0] z_z,
  output logic                              out_valid,
  output out_t                              out_data
);

  localparam int DIFF_WIDTH = PROD_WIDTH + 1;

  logic                         n_valid, p_valid;
  logic                         n_op, p_op, n_zero, p_zero;
  logic signed [AXIS_WIDTH-1:0] n      [3];
  logic signed [AXIS_WIDTH-1:0] p_n    [3];
  logic signed [PROD_WIDTH-1:0] pa     [3];
  logic signed [PROD_WIDTH-1:0] pb     [3];
  logic signed [AXIS_WIDTH-1:0] c      [3];
  out_t                         out_next;

  // Round a product difference to nearest, ties away from zero, then clamp.
  function automatic logic signed [AXIS_WIDTH-1:0] round_sat(
      input logic signed [DIFF_WIDTH-1:0] d, input logic flip);
    logic [DIFF_WIDTH-1:0]           mag;
    logic [DIFF_WIDTH-FRAC_BITS-1:0] r;
    logic [AXIS_WIDTH-1:0]           m;
    mag = d[DIFF_WIDTH-1] ? DIFF_WIDTH'(-d) : DIFF_WIDTH'(d);
    r   = (DIFF_WIDTH-FRAC_BITS)'((mag + (DIFF_WIDTH'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
    if (r > (DIFF_WIDTH-FRAC_BITS)'(1 << FRAC_BITS)) begin
      m = AXIS_WIDTH'(1 << FRAC_BITS);
    end else begin
      m = AXIS_WIDTH'(r);
    end
    return (d[DIFF_WIDTH-1] ^ flip) ? $signed(-m) : $signed(m);
  endfunction

  // Signed normal vector from the quotient magnitudes.
  always_ff @(posedge clk) begin
    n_op   <= in_data.opcode;
    n_zero <= in_data.zero;
    for (int i = 0; i < 3; i++) begin
      if (in_data.zero) begin
        n[i] <= '0;
      end else if (in_data.lane[i].neg) begin
        n[i] <= -$signed(AXIS_WIDTH'(in_data.lane[i].q));
      end else begin
        n[i] <= $signed(AXIS_WIDTH'(in_data.lane[i].q));
      end
    end
  end

  // Partial products of Z x n.
  always_ff @(posedge clk) begin
    p_op   <= n_op;
    p_zero <= n_zero;
    p_n    <= n;
    pa[0]  <= z_y * n[2];
    pb[0]  <= z_z * n[1];
    pa[1]  <= z_z * n[0];
    pb[1]  <= z_x * n[2];
    pa[2]  <= z_x * n[1];
    pb[2]  <= z_y * n[0];
  end

  // Y = Z x X directly; X = Y x Z is the same cross product negated.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i] = round_sat(DIFF_WIDTH'(pa[i]) - DIFF_WIDTH'(pb[i]), p_op == OP_VEC_IS_Y);
    end
    out_next.zero_length = p_zero;
    if (p_op == OP_VEC_IS_X) begin
      out_next.x_axis_x = p_n[0];
      out_next.x_axis_y = p_n[1];
      out_next.x_axis_z = p_n[2];
      out_next.y_axis_x = c[0];
      out_next.y_axis_y = c[1];
      out_next.y_axis_z = c[2];
    end else begin
      out_next.x_axis_x = c[0];
      out_next.x_axis_y = c[1];
      out_next.x_axis_z = c[2];
      out_next.y_axis_x = p_n[0];
      out_next.y_axis_y = p_n[1];
      out_next.y_axis_z = p_n[2];
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid   <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      n_valid   <= in_valid;
      p_valid   <= n_valid;
      out_valid <= p_valid;
    end
  end

endmodule

`default_nettype wire

@@ src/normalize_and_cross_view_axes_unit.sv @@
// Axis normaliser and cross-product former for a 3-D view frame.
//
// Command channel: start with cmd carries an opcode and a signed integer
// vector; a command is taken at each rising edge where start is high and busy
// is low. busy is always low, so a new command may be issued in every cycle.
// The vector is normalised to unit length in signed Q1.14 and the other axis
// is formed by a cross product with the configured Z axis.
// Result channel: done is high for one cycle with result; there is no
// back-pressure and results leave in command order.
// Pipeline: one square stage, one sum stage, one root cell per quotient bit,
// and the normal, product and rounding stages of the cross-product unit.
// Throughput: one command per cycle.
// Configuration: the Z axis registers sit on the APB port at byte addresses
// 0, 4 and 8. The user must write them only while no command is in flight;
// the block itself does not enforce this.
// Reset (rst, synchronous) empties the pipeline and loads Z = (0, 0, 1.0).

`default_nettype none

module normalize_and_cross_view_axes_unit import ncva_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_t                   cmd,
  output logic                       done,
  output out_t                       result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int STAGES = Q_WIDTH;

  logic [AXIS_WIDTH-1:0]        z_axis_x, z_axis_y, z_axis_z;
  logic signed [AXIS_WIDTH-1:0] zs_x, zs_y, zs_z;
  logic                         wr_en;
  logic [1:0]                   reg_idx;

  logic [2:0][IN_WIDTH-1:0]     vin;
  logic [IN_WIDTH-1:0]          mag      [3];
  logic                         a_valid;
  logic                         a_op;
  logic [2:0]                   a_neg;
  logic [SUM_WIDTH-1:0]         a_sq     [3];
  logic [SUM_WIDTH-1:0]         s_sum;
  cell_t                        head_next;
  logic                         chain_valid [STAGES+1];
  cell_t                        chain_data  [STAGES+1];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration registers.
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_WIDTH-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      z_axis_x <= '0;
      z_axis_y <= '0;
      z_axis_z <= AXIS_WIDTH'(1 << FRAC_BITS);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_Z_AXIS_X: z_axis_x <= pwdata[AXIS_WIDTH-1:0];
        REG_Z_AXIS_Y: z_axis_y <= pwdata[AXIS_WIDTH-1:0];
        REG_Z_AXIS_Z: z_axis_z <= pwdata[AXIS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_Z_AXIS_X: prdata = 32'(z_axis_x);
      REG_Z_AXIS_Y: prdata = 32'(z_axis_y);
      REG_Z_AXIS_Z: prdata = 32'(z_axis_z);
      default:      prdata = '0;
    endcase
  end

  // Clamp each Z component to +/-1.0 before it is used.
  function automatic logic signed [AXIS_WIDTH-1:0] sat_one(input logic [AXIS_WIDTH-1:0] v);
    logic signed [AXIS_WIDTH-1:0] sv;
    sv = $signed(v);
    if (sv > $signed(AXIS_WIDTH'(1 << FRAC_BITS))) begin
      return $signed(AXIS_WIDTH'(1 << FRAC_BITS));
    end else if (sv < -$signed(AXIS_WIDTH'(1 << FRAC_BITS))) begin
      return -$signed(AXIS_WIDTH'(1 << FRAC_BITS));
    end
    return sv;
  endfunction

  assign zs_x = sat_one(z_axis_x);
  assign zs_y = sat_one(z_axis_y);
  assign zs_z = sat_one(z_axis_z);

  // Square stage: magnitudes and their squares.
  assign vin = {cmd.vec_z, cmd.vec_y, cmd.vec_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vin[i][IN_WIDTH-1] ? (~vin[i] + 1'b1) : vin[i];
    end
  end

  always_ff @(posedge clk) begin
    a_op <= cmd.opcode;
    for (int i = 0; i < 3; i++) begin
      a_neg[i] <= vin[i][IN_WIDTH-1];
      a_sq[i]  <= SUM_WIDTH'(mag[i]) * SUM_WIDTH'(mag[i]);
    end
  end

  // Sum stage: length squared and the scaled right-hand sides.
  always_comb begin
    s_sum            = a_sq[0] + a_sq[1] + a_sq[2];
    head_next.opcode = a_op;
    head_next.zero   = (s_sum == '0);
    head_next.s      = s_sum;
    for (int i = 0; i < 3; i++) begin
      head_next.lane[i].r   = WIDE_WIDTH'(a_sq[i]) << (2 * FRAC_BITS + 2);
      head_next.lane[i].qs  = '0;
      head_next.lane[i].p   = '0;
      head_next.lane[i].q   = '0;
      head_next.lane[i].neg = a_neg[i];
    end
  end

  always_ff @(posedge clk) begin
    chain_data[0] <= head_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      chain_valid[0] <= 1'b0;
    end else begin
      a_valid        <= start && !busy;
      chain_valid[0] <= a_valid;
    end
  end

  // One root cell per quotient bit, most significant first.
  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    ncva_cell #(
      .BIT (FRAC_BITS - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  ncva_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[STAGES]),
    .in_data   (chain_data[STAGES]),
    .z_x       (zs_x),
    .z_y       (zs_y),
    .z_z       (zs_z),
    .out_valid (done),
    .out_data  (result)
  );

endmodule

`default_nettype wire

@@ src/ncva_checker.sv @@
`default_nettype none

module ncva_checker import ncva_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire out_t result
);

  // A done strobe follows each transfer after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("missing result after a command transfer");

  // No result appears without a command transfer the same latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LATENCY !done)
    else $error("result without a command transfer");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result straight after reset");

  // A zero vector gives all-zero axes.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_length) |->
      (result.x_axis_x == '0 && result.x_axis_y == '0 && result.x_axis_z == '0 &&
       result.y_axis_x == '0 && result.y_axis_y == '0 && result.y_axis_z == '0))
    else $error("zero vector gave non-zero axes");

endmodule

bind normalize_and_cross_view_axes_unit ncva_checker u_ncva_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import ncva_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  in_t                   cmd;
  logic                  done;
  out_t                  result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // Working copy of the Z axis registers, raw 16-bit values.
  logic [AXIS_WIDTH-1:0] z_reg [3];

  out_t axes_pending [$];
  int   fault_count;
  int   cycle_count;
  bit   idle_enable;

  normalize_and_cross_view_axes_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturate a value to plus or minus one in Q1.14.
  function automatic longint clamp_unit(longint v);
    longint one;
    one = longint'(1) << FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  // Nearest magnitude of |v| * 2^F / sqrt(s), found bit by bit on squares.
  function automatic longint unit_component(longint v, longint s);
    logic [127:0] rhs;
    logic [127:0] lhs;
    longint       mag;
    longint       q;
    longint       c;
    longint       t;
    mag = (v < 0) ? -v : v;
    q = 0;
    rhs = 128'(mag * mag) << (2 * FRAC_BITS + 2);
    for (int b = FRAC_BITS; b >= 0; b--) begin
      c = q | (longint'(1) << b);
      if (c <= (longint'(1) << FRAC_BITS)) begin
        t = 2 * c - 1;
        lhs = 128'(t * t) * 128'(s);
        if (lhs <= rhs) q = c;
      end
    end
    return (v < 0) ? -q : q;
  endfunction

  // Drop a product term from 2F to F fraction bits, ties away from zero.
  function automatic longint round_term(longint d);
    longint mag;
    longint r;
    mag = (d < 0) ? -d : d;
    r = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    return clamp_unit((d < 0) ? -r : r);
  endfunction

  // Predict both axes for one command under the current Z axis.
  function automatic out_t predict_axes(in_t c);
    longint v [3];
    longint n [3];
    longint z [3];
    longint a [3];
    longint b [3];
    longint xa [3];
    longint ya [3];
    longint s;
    out_t   o;
    v[0] = c.vec_x;
    v[1] = c.vec_y;
    v[2] = c.vec_z;
    s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    for (int i = 0; i < 3; i++) begin
      z[i] = clamp_unit(longint'($signed(z_reg[i])));
      n[i] = (s == 0) ? 0 : unit_component(v[i], s);
    end
    if (c.opcode == OP_VEC_IS_X) begin
      a = z;
      b = n;
    end else begin
      a = n;
      b = z;
    end
    xa = n;
    ya = n;
    if (c.opcode == OP_VEC_IS_X) begin
      ya[0] = round_term(a[1] * b[2] - a[2] * b[1]);
      ya[1] = round_term(a[2] * b[0] - a[0] * b[2]);
      ya[2] = round_term(a[0] * b[1] - a[1] * b[0]);
    end else begin
      xa[0] = round_term(a[1] * b[2] - a[2] * b[1]);
      xa[1] = round_term(a[2] * b[0] - a[0] * b[2]);
      xa[2] = round_term(a[0] * b[1] - a[1] * b[0]);
    end
    o.x_axis_x = AXIS_WIDTH'(xa[0]);
    o.x_axis_y = AXIS_WIDTH'(xa[1]);
    o.x_axis_z = AXIS_WIDTH'(xa[2]);
    o.y_axis_x = AXIS_WIDTH'(ya[0]);
    o.y_axis_y = AXIS_WIDTH'(ya[1]);
    o.y_axis_z = AXIS_WIDTH'(ya[2]);
    o.zero_length = (s == 0);
    return o;
  endfunction

  // Cycle counter with the overall time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (axes_pending.size() == 0) begin
        $error("result transfer with no command outstanding");
        fault_count++;
      end else begin
        want = axes_pending.pop_front();
        if (result.x_axis_x !== want.x_axis_x) begin
          $error("x_axis_x expected %0d got %0d", want.x_axis_x, result.x_axis_x);
          fault_count++;
        end
        if (result.x_axis_y !== want.x_axis_y) begin
          $error("x_axis_y expected %0d got %0d", want.x_axis_y, result.x_axis_y);
          fault_count++;
        end
        if (result.x_axis_z !== want.x_axis_z) begin
          $error("x_axis_z expected %0d got %0d", want.x_axis_z, result.x_axis_z);
          fault_count++;
        end
        if (result.y_axis_x !== want.y_axis_x) begin
          $error("y_axis_x expected %0d got %0d", want.y_axis_x, result.y_axis_x);
          fault_count++;
        end
        if (result.y_axis_y !== want.y_axis_y) begin
          $error("y_axis_y expected %0d got %0d", want.y_axis_y, result.y_axis_y);
          fault_count++;
        end
        if (result.y_axis_z !== want.y_axis_z) begin
          $error("y_axis_z expected %0d got %0d", want.y_axis_z, result.y_axis_z);
          fault_count++;
        end
        if (result.zero_length !== want.zero_length) begin
          $error("zero_length expected %0d got %0d", want.zero_length,
                 result.zero_length);
          fault_count++;
        end
      end
    end
  end

  // Send one command, with an optional random gap before it.
  task automatic send_vector(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_t c;
    int  gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    c.opcode = op;
    c.vec_x = x;
    c.vec_y = y;
    c.vec_z = z;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    axes_pending.push_back(predict_axes(c));
  endtask

  // Let the pipeline drain before touching configuration.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (axes_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // APB write of one Z axis register, then a read back.
  task automatic write_z(logic [1:0] idx, logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_WIDTH'(idx) << 2;
    pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    z_reg[idx] = value;
    @(posedge clk);
    if (prdata !== 32'(value)) begin
      $error("prdata expected %0h got %0h", 32'(value), prdata);
      fault_count++;
    end
  endtask

  task automatic set_z_axis(logic [15:0] zx, logic [15:0] zy, logic [15:0] zz);
    drain_pipeline();
    write_z(REG_Z_AXIS_X, zx);
    write_z(REG_Z_AXIS_Y, zy);
    write_z(REG_Z_AXIS_Z, zz);
  endtask

  function automatic logic [15:0] random_z();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] random_component();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'd0;
      3: return 16'($signed($urandom_range(0, 16)) - 8);
      4: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom());
    endcase
  endfunction

  // Field extremes, both opcodes, the zero vector, default Z axis.
  task automatic test_directed_vectors();
    for (int op = 0; op < 2; op++) begin
      send_vector(1'(op), 16'd0, 16'd0, 16'd0);
      send_vector(1'(op), 16'h7fff, 16'd0, 16'd0);
      send_vector(1'(op), 16'h8000, 16'd0, 16'd0);
      send_vector(1'(op), 16'd0, 16'h7fff, 16'd0);
      send_vector(1'(op), 16'd0, 16'd0, 16'h8000);
      send_vector(1'(op), 16'h8000, 16'h8000, 16'h8000);
      send_vector(1'(op), 16'h7fff, 16'h7fff, 16'h7fff);
      send_vector(1'(op), 16'd1, 16'd1, 16'd0);
      send_vector(1'(op), 16'hffff, 16'd1, 16'd1);
    end
  endtask

  // Out-of-range and extreme Z axis register settings.
  task automatic test_z_extremes();
    set_z_axis(16'h7fff, 16'h8000, 16'd0);
    send_vector(OP_VEC_IS_X, 16'd3, 16'd4, 16'd0);
    send_vector(OP_VEC_IS_Y, 16'h8000, 16'h7fff, 16'd5);
    set_z_axis(16'sd16384, 16'sd16384, 16'sd16384);
    send_vector(OP_VEC_IS_X, 16'd1, 16'hffff, 16'd0);
    send_vector(OP_VEC_IS_Y, 16'd1, 16'd0, 16'd0);
    set_z_axis(-16'sd16384, -16'sd16384, -16'sd16384);
    send_vector(OP_VEC_IS_X, 16'h7fff, 16'h8000, 16'h7fff);
    send_vector(OP_VEC_IS_Y, 16'd0, 16'd0, 16'd0);
  endtask

  // Random vectors over several random Z axis settings.
  task automatic test_random_vectors();
    for (int phase = 0; phase < 9; phase++) begin
      set_z_axis(random_z(), random_z(), random_z());
      idle_enable = (phase < 7);
      for (int k = 0; k < 200; k++)
        send_vector(1'($urandom_range(0, 1)), random_component(), random_component(),
                    random_component());
    end
  endtask

  initial begin
    cycle_count = 0;
    fault_count = 0;
    idle_enable = 1'b1;
    z_reg[0] = 16'd0;
    z_reg[1] = 16'd0;
    z_reg[2] = 16'sd16384;
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_vectors();
    test_z_extremes();
    test_random_vectors();

    drain_pipeline();
    if (fault_count == 0 && axes_pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ncva_pkg.sv
src/ncva_cell.sv
src/ncva_cross.sv
src/normalize_and_cross_view_axes_unit.sv
src/ncva_checker.sv
bench/testbench.sv
